/* hw/rtl/pcc_pkg.sv */
// Shared widths and transfer types for the permutation/combination counter.
package pcc_pkg;

    localparam int ARG_WIDTH    = 8;
    localparam int RESULT_WIDTH = 31;

    typedef struct packed {
        logic [ARG_WIDTH-1:0] n_value;
        logic [ARG_WIDTH-1:0] k_value;
    } pcc_in_t;

    typedef struct packed {
        logic [RESULT_WIDTH-1:0] perm_count;
        logic [RESULT_WIDTH-1:0] comb_count;
        logic                    overflow;
    } pcc_out_t;

endpackage

/* hw/rtl/permutation_and_combination_count_top.sv */
// Permutation count n!/(n-k)! and binomial coefficient C(n,k), saturating.
//
// Command channel: drive operands and raise start; the pair is taken at a
// clock edge where start is high and busy is low. busy stays high while the
// sequencer works. The result comes back on result, marked by done for exactly one cycle;
// the receiver cannot stall it and must take it then.
// k = 0 or k > n raises done in the cycle after the transfer.
// Otherwise each factor goes through the shared multiplier for the running
// product, then through it for the running coefficient, then through a
// one-bit-per-cycle restoring divider that forms all RESULT_WIDTH
// quotient bits, dividing by the step count. An overflowing factor ends
// the item at its first multiply. The product is at least k! after
// k steps and 13! passes the maximum, so at most 12 factors complete at
// the default width; busy drops with done.
// A new item may start in the cycle done is high.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, clears
// busy and done; no result is pending after reset.
module permutation_and_combination_count_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  pcc_pkg::pcc_in_t operands,
    output logic             done,
    output pcc_pkg::pcc_out_t result
);

    localparam int AW = pcc_pkg::ARG_WIDTH;
    localparam int RW = pcc_pkg::RESULT_WIDTH;
    localparam int CW = $clog2(RW + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_C,
        S_DIV
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      n_reg, n_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      step_reg, step_next;
    logic [RW-1:0]      perm_reg, perm_next;
    logic [RW-1:0]      quot_reg, quot_next;
    logic [AW-1:0]      rem_reg, rem_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               done_reg, done_next;
    pcc_pkg::pcc_out_t  result_reg, result_next;

    // shared multiplier: running value times current factor
    logic [AW-1:0]      factor;
    logic [AW-1:0]      divisor;
    logic [RW-1:0]      mul_a;
    logic [RW+AW-1:0]   mul_prod;
    logic [AW:0]        rem_shift;
    logic               sub_ok;
    logic [AW:0]        rem_diff;

    assign factor   = n_reg - step_reg;
    assign divisor  = step_reg + AW'(1);
    assign mul_a    = (state_reg == S_MUL_P) ? perm_reg : quot_reg;
    assign mul_prod = {{AW{1'b0}}, mul_a} * {{RW{1'b0}}, factor};

    assign rem_shift = {rem_reg, quot_reg[RW-1]};
    assign sub_ok    = rem_shift >= {1'b0, divisor};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        step_next   = step_reg;
        perm_next   = perm_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next    = operands.n_value;
                    k_next    = operands.k_value;
                    step_next = '0;
                    perm_next = RW'(1);
                    quot_next = RW'(1);
                    if (operands.k_value > operands.n_value)
                    begin
                        result_next.perm_count = '0;
                        result_next.comb_count = '0;
                        result_next.overflow   = 1'b0;
                        done_next              = 1'b1;
                    end
                    else if (operands.k_value == '0)
                    begin
                        result_next.perm_count = RW'(1);
                        result_next.comb_count = RW'(1);
                        result_next.overflow   = 1'b0;
                        done_next              = 1'b1;
                    end
                    else
                    begin
                        state_next = S_MUL_P;
                    end
                end
            end

            S_MUL_P:
            begin
                if (mul_prod[RW+AW-1:RW] != '0)
                begin
                    // product passed the maximum: saturate both results
                    result_next.perm_count = '1;
                    result_next.comb_count = '1;
                    result_next.overflow   = 1'b1;
                    done_next              = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    perm_next  = mul_prod[RW-1:0];
                    state_next = S_MUL_C;
                end
            end

            S_MUL_C:
            begin
                // C(n,i) * f = C(n,i+1) * (i+1) never exceeds the product
                quot_next  = mul_prod[RW-1:0];
                rem_next   = '0;
                cnt_next   = CW'(RW);
                state_next = S_DIV;
            end

            S_DIV:
            begin
                quot_next = {quot_reg[RW-2:0], sub_ok};
                rem_next  = sub_ok ? rem_diff[AW-1:0] : rem_shift[AW-1:0];
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    step_next = divisor;
                    if (divisor == k_reg)
                    begin
                        result_next.perm_count = perm_reg;
                        result_next.comb_count = {quot_reg[RW-2:0], sub_ok};
                        result_next.overflow   = 1'b0;
                        done_next              = 1'b1;
                        state_next             = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_MUL_P;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            n_reg      <= '0;
            k_reg      <= '0;
            step_reg   <= '0;
            perm_reg   <= '0;
            quot_reg   <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            step_reg   <= step_next;
            perm_reg   <= perm_next;
            quot_reg   <= quot_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // a result is only presented once the sequencer is back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done raised while busy");

    // a started item either finishes at once or keeps the sequencer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item dropped");

    // overflow always comes with both counts saturated
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |->
        (result.perm_count == '1 && result.comb_count == '1))
        else $error("overflow without saturation");

    // the coefficient never exceeds the permutation count
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.comb_count <= result.perm_count))
        else $error("comb_count above perm_count");

    // divider runs for a nonzero count only
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg != '0))
        else $error("divider count underflow");

endmodule
